// ===== hw/rtl/xrng_pkg.sv =====
package xrng_pkg;

	localparam logic [63:0] SM_GAMMA = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [63:0] SM_MUL1  = 64'hbf58_476d_1ce4_e5b9;
	localparam logic [63:0] SM_MUL2  = 64'h94d0_49bb_1331_11eb;

	localparam int unsigned SM_SHIFT_A = 30;
	localparam int unsigned SM_SHIFT_B = 27;
	localparam int unsigned SM_SHIFT_C = 31;
	localparam int unsigned XS_SHIFT   = 17;
	localparam int unsigned XS_ROT     = 45;
	localparam int unsigned FRAC_SHIFT = 11;

	localparam logic FUNC_SEED = 1'b0;
	localparam logic FUNC_DRAW = 1'b1;

	typedef enum logic [3:0] {
		ST_ADD,
		ST_M1_LO,
		ST_M1_H1,
		ST_M1_H2,
		ST_MIX1,
		ST_M2_LO,
		ST_M2_H1,
		ST_M2_H2,
		ST_MIX2,
		ST_IDLE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DRAW,
		OP_ADD,
		OP_MUL_LO,
		OP_MUL_H1,
		OP_MUL_H2,
		OP_MIX1,
		OP_MIX2
	} op_t;

	typedef struct packed {
		op_t  op;
		logic k_sel;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic last_word;
	} stat_t;

endpackage

// ===== hw/rtl/xrng_req_if.sv =====
interface xrng_req_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic signed [31:0] seed_value;

	modport source (output valid, output func, output seed_value, input ready);
	modport sink (input valid, input func, input seed_value, output ready);
endinterface

// ===== hw/rtl/xrng_rsp_if.sv =====
interface xrng_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] random_word;
	logic [52:0] unit_fraction;

	modport source (output valid, output random_word, output unit_fraction, input ready);
	modport sink (input valid, input random_word, input unit_fraction, output ready);
endinterface

// ===== hw/rtl/xrng_ctrl.sv =====
module xrng_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_func,
	input  xrng_pkg::stat_t stat,
	output logic          req_ready,
	output xrng_pkg::cmd_t  cmd
);
	import xrng_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ADD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.op    = OP_NONE;
		cmd.k_sel = 1'b0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_ADD: begin
				cmd.op  = OP_ADD;
				state_d = ST_M1_LO;
			end
			ST_M1_LO: begin
				cmd.op  = OP_MUL_LO;
				state_d = ST_M1_H1;
			end
			ST_M1_H1: begin
				cmd.op  = OP_MUL_H1;
				state_d = ST_M1_H2;
			end
			ST_M1_H2: begin
				cmd.op  = OP_MUL_H2;
				state_d = ST_MIX1;
			end
			ST_MIX1: begin
				cmd.op  = OP_MIX1;
				state_d = ST_M2_LO;
			end
			ST_M2_LO: begin
				cmd.op    = OP_MUL_LO;
				cmd.k_sel = 1'b1;
				state_d   = ST_M2_H1;
			end
			ST_M2_H1: begin
				cmd.op    = OP_MUL_H1;
				cmd.k_sel = 1'b1;
				state_d   = ST_M2_H2;
			end
			ST_M2_H2: begin
				cmd.op    = OP_MUL_H2;
				cmd.k_sel = 1'b1;
				state_d   = ST_MIX2;
			end
			ST_MIX2: begin
				cmd.op  = OP_MIX2;
				state_d = stat.last_word ? ST_IDLE : ST_ADD;
			end
			ST_IDLE: begin
				req_ready = stat.out_free;
				if (req_valid && stat.out_free) begin
					if (req_func == FUNC_DRAW) begin
						cmd.op = OP_DRAW;
					end else begin
						cmd.op  = OP_LOAD;
						state_d = ST_ADD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

// ===== hw/rtl/xrng_dp.sv =====
module xrng_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  xrng_pkg::cmd_t     cmd,
	input  logic signed [31:0] seed_value,
	input  logic               rsp_ready,
	output xrng_pkg::stat_t    stat,
	output logic               rsp_valid,
	output logic [63:0]        random_word,
	output logic [52:0]        unit_fraction
);
	import xrng_pkg::*;

	logic [63:0] ctr_q;
	logic [63:0] z_q;
	logic [63:0] acc_q;
	logic [1:0]  idx_q;
	logic [63:0] gen_q [4];
	logic [63:0] word_q;
	logic        valid_q;

	logic [63:0] ctr_sum;
	logic [63:0] k_sel;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [63:0] t_word;
	logic [63:0] n0, n1, n2, n3;

	assign ctr_sum = ctr_q + SM_GAMMA;
	assign k_sel   = cmd.k_sel ? SM_MUL2 : SM_MUL1;
	assign mul_a   = (cmd.op == OP_MUL_H1) ? z_q[63:32] : z_q[31:0];
	assign mul_b   = (cmd.op == OP_MUL_H2) ? k_sel[63:32] : k_sel[31:0];
	assign prod    = 64'(mul_a) * 64'(mul_b);

	assign t_word = gen_q[1] << XS_SHIFT;
	assign n2     = gen_q[2] ^ gen_q[0];
	assign n3     = gen_q[3] ^ gen_q[1];
	assign n1     = gen_q[1] ^ n2;
	assign n0     = gen_q[0] ^ n3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q   <= '0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_LOAD: begin
					ctr_q <= {{32{seed_value[31]}}, seed_value};
					idx_q <= '0;
				end
				OP_ADD: begin
					ctr_q <= ctr_sum;
				end
				OP_MIX2: begin
					idx_q <= idx_q + 2'd1;
				end
				default: begin
				end
			endcase
			if (cmd.op == OP_DRAW) begin
				valid_q <= 1'b1;
			end else if (rsp_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op) inside
			OP_ADD: begin
				z_q <= ctr_sum ^ (ctr_sum >> SM_SHIFT_A);
			end
			OP_MUL_LO: begin
				acc_q <= prod;
			end
			OP_MUL_H1, OP_MUL_H2: begin
				acc_q[63:32] <= acc_q[63:32] + prod[31:0];
			end
			OP_MIX1: begin
				z_q <= acc_q ^ (acc_q >> SM_SHIFT_B);
			end
			OP_MIX2: begin
				gen_q[idx_q] <= acc_q ^ (acc_q >> SM_SHIFT_C);
			end
			OP_DRAW: begin
				word_q   <= gen_q[0] + gen_q[3];
				gen_q[0] <= n0;
				gen_q[1] <= n1;
				gen_q[2] <= n2 ^ t_word;
				gen_q[3] <= {n3[63-XS_ROT:0], n3[63:64-XS_ROT]};
			end
			default: begin
			end
		endcase
	end

	assign stat.out_free  = !valid_q || rsp_ready;
	assign stat.last_word = (idx_q == 2'd3);
	assign rsp_valid      = valid_q;
	assign random_word    = word_q;
	assign unit_fraction  = word_q[63:FRAC_SHIFT];
endmodule

// ===== hw/rtl/xoshiro256plus_rng_with_seeding.sv =====
// xoshiro256+ generator with SplitMix64 seeding. A draw request (func = 1) returns the sum of
// state words 0 and 3 plus its top 53 bits as a fraction of 2^53, and draws are taken one per
// cycle as long as the result register drains. A seed request (func = 0) gives no response and
// keeps req.ready low while the four state words are rebuilt: each SplitMix64 word is paced
// by the single shared 32x32 multiplier that forms each 64-bit product in three partial steps.
// After reset the block runs the same pass with seed 0 before it first raises req.ready.
module xoshiro256plus_rng_with_seeding (
	input logic        clk,
	input logic        arst_n,
	xrng_req_if.sink   req,
	xrng_rsp_if.source rsp
);
	import xrng_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  req_ready;

	xrng_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req.func),
		.stat      (stat),
		.req_ready (req_ready),
		.cmd       (cmd)
	);

	xrng_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.seed_value    (req.seed_value),
		.rsp_ready     (rsp.ready),
		.stat          (stat),
		.rsp_valid     (rsp.valid),
		.random_word   (rsp.random_word),
		.unit_fraction (rsp.unit_fraction)
	);

	assign req.ready = req_ready;

`ifndef SYNTHESIS
	a_seed_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && (req.func == FUNC_SEED) |=> !req.ready)
		else $error("request taken right after seed");

	a_rsp_from_draw: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(req.valid && req.ready && (req.func == FUNC_DRAW)))
		else $error("response without draw");

	a_fraction: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.unit_fraction == rsp.random_word[63:FRAC_SHIFT]))
		else $error("fraction mismatch");
`endif
endmodule

// ===== test/xoshiro256plus_rng_with_seeding_test.sv =====
module xoshiro256plus_rng_with_seeding_test;
	import xrng_pkg::*;

	typedef struct {
		logic               func;
		logic signed [31:0] seed_value;
		bit                 wait_drain;
	} rng_request_t;

	typedef struct {
		logic [63:0] random_word;
		logic [52:0] unit_fraction;
	} draw_result_t;

	localparam int RANDOM_REQUESTS = 833;
	localparam int TAIL_REQUESTS   = 100;
	localparam int SETTLE_CYCLES   = 48;

	logic clk;
	logic arst_n;

	xrng_req_if req ();
	xrng_rsp_if rsp ();

	xoshiro256plus_rng_with_seeding dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	logic [63:0]  gen_word [4];
	rng_request_t requests_to_send [$];
	draw_result_t draws_due [$];

	int  total_requests;
	int  requests_done;
	int  seeds_done;
	int  draws_checked;
	int  failures;
	int  send_gap;
	int  recv_stall;
	int  long_hold;
	bit  long_hold_done;
	bit  req_accepted;

	function automatic void seed_state(logic signed [31:0] seed);
		logic [63:0] ctr;
		logic [63:0] z;
		ctr = {{32{seed[31]}}, seed};
		for (int i = 0; i < 4; i++) begin
			ctr = ctr + SM_GAMMA;
			z = ctr;
			z = (z ^ (z >> SM_SHIFT_A)) * SM_MUL1;
			z = (z ^ (z >> SM_SHIFT_B)) * SM_MUL2;
			gen_word[i] = z ^ (z >> SM_SHIFT_C);
		end
	endfunction

	function automatic draw_result_t next_draw();
		logic [63:0] sum;
		logic [63:0] t;
		draw_result_t r;
		sum = gen_word[0] + gen_word[3];
		t = gen_word[1] << XS_SHIFT;
		gen_word[2] = gen_word[2] ^ gen_word[0];
		gen_word[3] = gen_word[3] ^ gen_word[1];
		gen_word[1] = gen_word[1] ^ gen_word[2];
		gen_word[0] = gen_word[0] ^ gen_word[3];
		gen_word[2] = gen_word[2] ^ t;
		gen_word[3] = (gen_word[3] << XS_ROT) | (gen_word[3] >> (64 - XS_ROT));
		r.random_word = sum;
		r.unit_fraction = sum[63:FRAC_SHIFT];
		return r;
	endfunction

	task automatic add_request(logic func, logic signed [31:0] seed, bit wait_drain);
		rng_request_t r;
		r.func = func;
		r.seed_value = seed;
		r.wait_drain = wait_drain;
		requests_to_send.push_back(r);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// request side: acceptance, prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready) begin
				req_accepted = 1'b1;
				requests_done++;
				if (req.func == FUNC_DRAW) begin
					draws_due.push_back(next_draw());
				end else begin
					seed_state(req.seed_value);
					seeds_done++;
				end
			end
		end
	end

	// response side: check against oldest pending draw
	always @(posedge clk) begin : check_rsp
		draw_result_t exp_r;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (draws_due.size() == 0) begin
				$display("%0t: unexpected response, random_word %h", $time, rsp.random_word);
				failures++;
			end else begin
				exp_r = draws_due.pop_front();
				draws_checked++;
				if (rsp.random_word !== exp_r.random_word) begin
					$display("%0t: random_word mismatch, expected %h, actual %h", $time,
						exp_r.random_word, rsp.random_word);
					failures++;
				end
				if (rsp.unit_fraction !== exp_r.unit_fraction) begin
					$display("%0t: unit_fraction mismatch, expected %h, actual %h", $time,
						exp_r.unit_fraction, rsp.unit_fraction);
					failures++;
				end
			end
		end
	end

	always @(negedge clk) begin : drive_req
		rng_request_t item;
		if (arst_n) begin
			if (req.valid && !req_accepted) begin
				// hold until taken
			end else begin
				req_accepted = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
					req.valid <= 1'b0;
				end else if (requests_to_send.size() == 0) begin
					req.valid <= 1'b0;
				end else if (requests_to_send[0].wait_drain && draws_due.size() != 0) begin
					req.valid <= 1'b0;
				end else if (requests_to_send.size() > TAIL_REQUESTS &&
						$urandom_range(0, 15) == 0) begin
					send_gap = $urandom_range(1, 11) - 1;
					req.valid <= 1'b0;
				end else begin
					item = requests_to_send.pop_front();
					req.valid <= 1'b1;
					req.func <= item.func;
					req.seed_value <= item.seed_value;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!long_hold_done && draws_checked >= 150) begin
				long_hold = 160;
				long_hold_done = 1'b1;
			end
			if (long_hold > 0) begin
				long_hold--;
				rsp.ready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				rsp.ready <= 1'b0;
			end else if (requests_to_send.size() > TAIL_REQUESTS &&
					$urandom_range(0, 11) == 0) begin
				recv_stall = $urandom_range(1, 11) - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	initial begin
		req.valid = 1'b0;
		req.func = FUNC_DRAW;
		req.seed_value = '0;
		rsp.ready = 1'b0;
		arst_n = 1'b0;
		seed_state(32'sd0);

		// reset state, seed ignored on draw
		add_request(FUNC_DRAW, 32'h8000_0000, 1'b0);
		add_request(FUNC_DRAW, 32'h7fff_ffff, 1'b0);
		add_request(FUNC_DRAW, 32'hffff_ffff, 1'b0);
		add_request(FUNC_SEED, 32'h0000_0000, 1'b0);
		add_request(FUNC_DRAW, 32'h0000_0000, 1'b0);
		add_request(FUNC_DRAW, 32'h1234_5678, 1'b0);
		add_request(FUNC_SEED, 32'h7fff_ffff, 1'b0);
		add_request(FUNC_DRAW, 32'h0000_0000, 1'b0);
		add_request(FUNC_SEED, 32'h8000_0000, 1'b0);
		add_request(FUNC_DRAW, 32'hffff_ffff, 1'b0);
		add_request(FUNC_SEED, 32'hffff_ffff, 1'b0);
		add_request(FUNC_DRAW, 32'h0000_0000, 1'b0);
		add_request(FUNC_DRAW, 32'h0000_0000, 1'b0);
		// back-to-back reseeds: only the last counts
		add_request(FUNC_SEED, 32'h0000_0001, 1'b0);
		add_request(FUNC_SEED, 32'h0000_0005, 1'b0);
		add_request(FUNC_DRAW, 32'h0000_0000, 1'b0);
		add_request(FUNC_DRAW, 32'h5555_aaaa, 1'b1);

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			add_request(($urandom_range(0, 9) == 0) ? FUNC_SEED : FUNC_DRAW, $urandom,
				((i % 211) == 105) && (i < RANDOM_REQUESTS - TAIL_REQUESTS));
		end
		total_requests = requests_to_send.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (requests_done < total_requests || draws_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d requests (%0d reseeds) with random gaps and backpressure;",
			requests_done, seeds_done);
		$display("checked %0d draws, including a long response hold and drain pauses.",
			draws_checked);
		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/xrng_pkg.sv
hw/rtl/xrng_req_if.sv
hw/rtl/xrng_rsp_if.sv
hw/rtl/xrng_ctrl.sv
hw/rtl/xrng_dp.sv
hw/rtl/xoshiro256plus_rng_with_seeding.sv
test/xoshiro256plus_rng_with_seeding_test.sv
